// ----- hdl/kil_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kil_pkg
// Shared types and constants of the keyframe interval lookup: widths, register
// indexes, controller states and the controller/datapath command and status
// groups.
// ----------------------------------------------------------------------------
package kil_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int TIME_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd1;

    localparam logic KIND_KEY_WRITE = 1'b0;
    localparam logic KIND_QUERY     = 1'b1;

    localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_PROBE,
        ST_COMPARE,
        ST_RD_BEFORE,
        ST_RD_AFTER,
        ST_DIV_SETUP,
        ST_DIV,
        ST_FINISH
    } kil_state_t;

    typedef struct packed {
        logic key_wr;
        logic load;
        logic mod_step;
        logic probe_rd;
        logic probe_cmp;
        logic rd_before;
        logic rd_after;
        logic div_setup;
        logic div_step;
        logic out_load;
    } kil_cmd_t;

    typedef struct packed {
        logic few_keys;
        logic mod_last;
        logic div_last;
        logic span_zero;
        logic pos_past;
        logic pos_zero;
        logic out_free;
    } kil_stat_t;

endpackage
`default_nettype wire

// ----- hdl/kil_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kil_ctrl
// Controller of the keyframe interval lookup: sequences the modulo, the
// binary search, the bracketing key reads and the fraction division.
// ----------------------------------------------------------------------------
module kil_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               kind,
    output logic                    in_ready,
    input  wire kil_pkg::kil_stat_t stat,
    output kil_pkg::kil_cmd_t       cmd
);

    kil_pkg::kil_state_t state_reg;
    kil_pkg::kil_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kil_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kil_pkg::ST_IDLE:
            begin
                if (in_valid && (kind == kil_pkg::KIND_QUERY))
                begin
                    state_next = kil_pkg::ST_MOD;
                end
            end
            kil_pkg::ST_MOD:
            begin
                if (stat.mod_last)
                begin
                    state_next = kil_pkg::ST_CHECK;
                end
            end
            kil_pkg::ST_CHECK:
            begin
                state_next = stat.few_keys ? kil_pkg::ST_FINISH : kil_pkg::ST_PROBE;
            end
            kil_pkg::ST_PROBE:
            begin
                priority if (!stat.span_zero)
                begin
                    state_next = kil_pkg::ST_COMPARE;
                end
                else if (stat.pos_past || stat.pos_zero)
                begin
                    state_next = kil_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = kil_pkg::ST_RD_BEFORE;
                end
            end
            kil_pkg::ST_COMPARE:   state_next = kil_pkg::ST_PROBE;
            kil_pkg::ST_RD_BEFORE: state_next = kil_pkg::ST_RD_AFTER;
            kil_pkg::ST_RD_AFTER:  state_next = kil_pkg::ST_DIV_SETUP;
            kil_pkg::ST_DIV_SETUP: state_next = kil_pkg::ST_DIV;
            kil_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = kil_pkg::ST_FINISH;
                end
            end
            kil_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = kil_pkg::ST_IDLE;
                end
            end
            default: state_next = kil_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            kil_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.key_wr = in_valid && (kind == kil_pkg::KIND_KEY_WRITE);
                cmd.load   = in_valid && (kind == kil_pkg::KIND_QUERY);
            end
            kil_pkg::ST_MOD:       cmd.mod_step  = 1'b1;
            kil_pkg::ST_CHECK:     cmd           = '0;
            kil_pkg::ST_PROBE:     cmd.probe_rd  = !stat.span_zero;
            kil_pkg::ST_COMPARE:   cmd.probe_cmp = 1'b1;
            kil_pkg::ST_RD_BEFORE: cmd.rd_before = 1'b1;
            kil_pkg::ST_RD_AFTER:  cmd.rd_after  = 1'b1;
            kil_pkg::ST_DIV_SETUP: cmd.div_setup = 1'b1;
            kil_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            kil_pkg::ST_FINISH:    cmd.out_load  = stat.out_free;
            default:               cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/kil_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kil_dp
// Datapath of the keyframe interval lookup: configuration registers, key
// table, bit-serial modulo, search registers, bit-serial fraction divider
// and the result register.
// ----------------------------------------------------------------------------
module kil_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire kil_pkg::kil_cmd_t                  cmd,
    output kil_pkg::kil_stat_t                      stat,
    input  wire logic                               cfg_we,
    input  wire logic [kil_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kil_pkg::TIME_W-1:0]         cfg_data,
    input  wire logic [kil_pkg::IDX_W-1:0]          key_index,
    input  wire logic [kil_pkg::TIME_W-1:0]         key_time,
    input  wire logic [kil_pkg::TIME_W-1:0]         query_time,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic                                    found,
    output logic [kil_pkg::IDX_W-1:0]               frame_before,
    output logic [kil_pkg::IDX_W-1:0]               frame_after,
    output logic [kil_pkg::FRAC_W-1:0]              fraction
);

    localparam int TW = kil_pkg::TIME_W;
    localparam int CW = kil_pkg::CNT_W;
    localparam int AW = kil_pkg::IDX_W;
    localparam int FB = kil_pkg::FRAC_BITS;
    localparam int SW = kil_pkg::STEP_W;

    logic [TW-1:0] duration_reg;
    logic [CW-1:0] key_count_reg;

    logic [TW-1:0] key_mem [kil_pkg::MAX_KEYS];
    logic [TW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_sat;
    logic [SW-1:0] step_reg;
    logic [TW:0]   modulus;
    logic [TW:0]   rem_reg;
    logic [TW-1:0] dividend_reg;
    logic [TW+1:0] mod_trial;

    logic [CW-1:0] base_reg;
    logic [CW-1:0] span_reg;
    logic [CW-1:0] half;
    logic [CW-1:0] probe;
    logic [CW-1:0] base_dec;

    logic [TW-1:0] kb_reg;
    logic [TW-1:0] num;
    logic [TW-1:0] den;
    logic [TW-1:0] den_reg;
    logic [TW-1:0] drem_reg;
    logic [TW:0]   div_trial;
    logic [FB-1:0] quo_reg;
    logic          sat_reg;

    logic          out_valid_reg;
    logic          found_reg;
    logic [AW-1:0] before_reg;
    logic [AW-1:0] after_reg;
    logic [kil_pkg::FRAC_W-1:0] frac_reg;
    logic [CW-1:0] n_less1;
    logic [CW-1:0] n_less2;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= '0;
            key_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == kil_pkg::CFG_DURATION)
            begin
                duration_reg <= cfg_data;
            end
            else if (cfg_index == kil_pkg::CFG_KEY_COUNT)
            begin
                key_count_reg <= cfg_data[CW-1:0];
            end
        end
    end

    assign n_sat = (key_count_reg > CW'(kil_pkg::MAX_KEYS)) ?
                   CW'(kil_pkg::MAX_KEYS) : key_count_reg;

    // key table, one write and one registered read port
    assign half     = {1'b0, span_reg[CW-1:1]};
    assign probe    = base_reg + half;
    assign base_dec = base_reg - CW'(1);
    assign rd_en    = cmd.probe_rd || cmd.rd_before || cmd.rd_after;

    always_comb
    begin
        priority if (cmd.rd_before)
        begin
            rd_addr = base_dec[AW-1:0];
        end
        else if (cmd.rd_after)
        begin
            rd_addr = base_reg[AW-1:0];
        end
        else
        begin
            rd_addr = probe[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_wr)
        begin
            key_mem[key_index] <= key_time;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    // restoring modulo, one quotient bit per cycle
    assign modulus   = {1'b0, duration_reg} + (TW+1)'(1);
    assign mod_trial = {rem_reg, dividend_reg[TW-1]};

    // fraction division, one bit per cycle
    assign num       = rem_reg[TW-1:0] - kb_reg;
    assign den       = rd_data_reg - kb_reg;
    assign div_trial = {drem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            n_reg    <= '0;
            base_reg <= '0;
            span_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
                n_reg    <= n_sat;
                base_reg <= '0;
                span_reg <= n_sat;
            end
            else if (cmd.div_setup)
            begin
                step_reg <= '0;
            end
            else if (cmd.mod_step || cmd.div_step)
            begin
                step_reg <= step_reg + SW'(1);
            end

            if (cmd.probe_cmp)
            begin
                if (rd_data_reg < rem_reg[TW-1:0])
                begin
                    base_reg <= probe + CW'(1);
                    span_reg <= span_reg - half - CW'(1);
                end
                else
                begin
                    span_reg <= half;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg      <= '0;
            dividend_reg <= query_time;
        end
        else if (cmd.mod_step)
        begin
            dividend_reg <= {dividend_reg[TW-2:0], 1'b0};
            if (mod_trial >= {1'b0, modulus})
            begin
                rem_reg <= (TW+1)'(mod_trial - {1'b0, modulus});
            end
            else
            begin
                rem_reg <= mod_trial[TW:0];
            end
        end

        if (cmd.rd_after)
        begin
            kb_reg <= rd_data_reg;
        end

        if (cmd.div_setup)
        begin
            drem_reg <= num;
            den_reg  <= den;
            sat_reg  <= (num >= den);
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_trial >= {1'b0, den_reg})
            begin
                drem_reg <= TW'(div_trial - {1'b0, den_reg});
                quo_reg  <= {quo_reg[FB-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= div_trial[TW-1:0];
                quo_reg  <= {quo_reg[FB-2:0], 1'b0};
            end
        end
    end

    // result register
    assign n_less1 = n_reg - CW'(1);
    assign n_less2 = n_reg - CW'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg <= (n_reg != '0);
            priority if (stat.few_keys || stat.pos_zero)
            begin
                before_reg <= '0;
                after_reg  <= '0;
                frac_reg   <= '0;
            end
            else if (stat.pos_past)
            begin
                before_reg <= n_less2[AW-1:0];
                after_reg  <= n_less1[AW-1:0];
                frac_reg   <= kil_pkg::Q16_ONE;
            end
            else
            begin
                before_reg <= base_dec[AW-1:0];
                after_reg  <= base_reg[AW-1:0];
                frac_reg   <= sat_reg ? kil_pkg::Q16_ONE : {1'b0, quo_reg};
            end
        end
    end

    assign stat.few_keys  = (n_reg < CW'(2));
    assign stat.mod_last  = (step_reg == SW'(TW - 1));
    assign stat.div_last  = (step_reg == SW'(FB - 1));
    assign stat.span_zero = (span_reg == '0);
    assign stat.pos_past  = (base_reg >= n_reg);
    assign stat.pos_zero  = (base_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign frame_before = before_reg;
    assign frame_after  = after_reg;
    assign fraction     = frac_reg;

endmodule
`default_nettype wire

// ----- hdl/keyframe_interval_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_interval_lookup
// Key time table with a binary search for the keys that bracket a wrapped
// query time and the Q16 interpolation fraction between them.
// ----------------------------------------------------------------------------
// key write: no result; in_ready stays high, so a query can be taken in the next cycle
// query: one query at a time; the time from transfer to result is set by
// the 32-step bit-serial modulo, a search step of ST_PROBE and ST_COMPARE on the
// single table read port, and the 16-step bit-serial fraction divider
// reset clears duration and key_count; table contents are undefined until written
module keyframe_interval_lookup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kil_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kil_pkg::TIME_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [kil_pkg::IDX_W-1:0]     key_index,
    input  wire logic [kil_pkg::TIME_W-1:0]    key_time,
    input  wire logic [kil_pkg::TIME_W-1:0]    query_time,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic [kil_pkg::IDX_W-1:0]          frame_before,
    output logic [kil_pkg::IDX_W-1:0]          frame_after,
    output logic [kil_pkg::FRAC_W-1:0]         fraction
);

    kil_pkg::kil_cmd_t  cmd;
    kil_pkg::kil_stat_t stat;

    assign cfg_ready = 1'b1;

    kil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kil_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_index    (key_index),
        .key_time     (key_time),
        .query_time   (query_time),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .found        (found),
        .frame_before (frame_before),
        .frame_after  (frame_after),
        .fraction     (fraction)
    );

endmodule
`default_nettype wire
